/* sv/clfr_pkg.sv */
// Shared types, constants and helper functions for the Content-Length deframer.
package clfr_pkg;

	localparam int MAX_LINE_CHARS = 1023;
	localparam int LINE_BITS      = $clog2(MAX_LINE_CHARS + 1);
	localparam int LENGTH_BITS    = 64;
	localparam int LEN_OUT_W      = 64;
	localparam int KEY_LEN        = 14;
	localparam int KEY_POS_BITS   = $clog2(KEY_LEN + 1);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		MODE_HEADERS = 2'd0,
		MODE_WAIT    = 2'd1,
		MODE_DATA    = 2'd2,
		MODE_SKIP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_BODY = 2'd1,
		PH_TAIL = 2'd2,
		PH_BAD  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_FILE_REQ = 3'd1,
		KIND_GO       = 3'd2,
		KIND_NO_GO    = 3'd3,
		KIND_ABORTED  = 3'd4,
		KIND_NO_COLON = 3'd5,
		KIND_BAD_LEN  = 3'd6,
		KIND_TOO_LONG = 3'd7
	} kind_t;

	typedef enum logic {
		OP_BYTE     = 1'b0,
		OP_DECISION = 1'b1
	} opcode_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       accept;
	} item_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           payload_byte;
		logic                 last;
		logic [LEN_OUT_W-1:0] length;
	} result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// "Content-Length", one character per position
	function automatic logic [7:0] key_text(input logic [KEY_POS_BITS-1:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = "C";
			4'd1:    ch = "o";
			4'd2:    ch = "n";
			4'd3:    ch = "t";
			4'd4:    ch = "e";
			4'd5:    ch = "n";
			4'd6:    ch = "t";
			4'd7:    ch = "-";
			4'd8:    ch = "L";
			4'd9:    ch = "e";
			4'd10:   ch = "n";
			4'd11:   ch = "g";
			4'd12:   ch = "t";
			4'd13:   ch = "h";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* sv/clfr_in_reg.sv */
// Input register stage: holds one request until the core consumes it.
module clfr_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  clfr_pkg::item_t item_in,
	input  logic           advance,
	output logic           valid_s1,
	output clfr_pkg::item_t item_s1
);

	logic take;

	assign item_ready = !valid_s1 || advance;
	assign take       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

/* sv/clfr_core.sv */
// Header parser, decision handling and payload counter; one request per cycle while advance is high.
module clfr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  clfr_pkg::item_t  item,
	output logic             res_valid,
	output clfr_pkg::result_t res
);

	localparam int LB = clfr_pkg::LENGTH_BITS;
	localparam int LW = clfr_pkg::LINE_BITS;
	localparam int KW = clfr_pkg::KEY_POS_BITS;

	clfr_pkg::mode_t  mode_q, mode_d;
	clfr_pkg::phase_t key_phase_q, key_phase_d;
	clfr_pkg::phase_t value_phase_q, value_phase_d;
	logic [LW-1:0]    line_chars_q, line_chars_d;
	logic [KW-1:0]    key_pos_q, key_pos_d;
	logic             colon_seen_q, colon_seen_d;
	logic [LB-1:0]    value_acc_q, value_acc_d;
	logic             value_ovf_q, value_ovf_d;
	logic [LB-1:0]    file_len_q, file_len_d;
	logic [LB-1:0]    remain_q, remain_d;

	logic [7:0]    c;
	logic          ws, digit, lf;
	logic          key_ok, value_ok, line_full, clr;
	logic [LB+3:0] acc_next;
	logic          acc_ovf;

	assign c         = item.data_byte;
	assign ws        = clfr_pkg::is_ws(c);
	assign digit     = clfr_pkg::is_digit(c);
	assign lf        = (c == clfr_pkg::CH_LF);
	assign line_full = (line_chars_q >= LW'(clfr_pkg::MAX_LINE_CHARS));

	assign key_ok = (key_phase_q == clfr_pkg::PH_BODY && key_pos_q == KW'(clfr_pkg::KEY_LEN))
		|| key_phase_q == clfr_pkg::PH_TAIL;
	assign value_ok = (value_phase_q == clfr_pkg::PH_BODY
		|| value_phase_q == clfr_pkg::PH_TAIL) && !value_ovf_q;

	// acc*10 + digit; anything above LB bits is an overflow
	assign acc_next = {1'b0, value_acc_q, 3'b000} + {3'b000, value_acc_q, 1'b0}
		+ (LB + 4)'(c - clfr_pkg::CH_ZERO);
	assign acc_ovf  = (acc_next[LB+3:LB] != 4'd0);

	// next state
	always_comb begin
		mode_d        = mode_q;
		key_phase_d   = key_phase_q;
		value_phase_d = value_phase_q;
		line_chars_d  = line_chars_q;
		key_pos_d     = key_pos_q;
		colon_seen_d  = colon_seen_q;
		value_acc_d   = value_acc_q;
		value_ovf_d   = value_ovf_q;
		file_len_d    = file_len_q;
		remain_d      = remain_q;
		clr           = 1'b0;
		if (advance) begin
			if (item.opcode == clfr_pkg::OP_DECISION) begin
				if (mode_q == clfr_pkg::MODE_WAIT && item.accept) begin
					remain_d = file_len_q;
					mode_d   = (file_len_q == '0) ? clfr_pkg::MODE_HEADERS : clfr_pkg::MODE_DATA;
				end
			end else begin
				unique case (mode_q)
					clfr_pkg::MODE_WAIT: begin
						mode_d = clfr_pkg::MODE_HEADERS;
						clr    = 1'b1;
					end
					clfr_pkg::MODE_DATA: begin
						remain_d = remain_q - LB'(1);
						if (remain_q == LB'(1)) begin
							mode_d = clfr_pkg::MODE_HEADERS;
							clr    = 1'b1;
						end
					end
					clfr_pkg::MODE_SKIP: begin
						if (lf) begin
							mode_d = clfr_pkg::MODE_HEADERS;
							clr    = 1'b1;
						end
					end
					clfr_pkg::MODE_HEADERS: begin
						if (lf) begin
							clr = 1'b1;
							if (line_chars_q == '0) begin
								mode_d = clfr_pkg::MODE_WAIT;
							end else if (colon_seen_q && key_ok && value_ok) begin
								file_len_d = value_acc_q;
							end
						end else if (line_full) begin
							mode_d = clfr_pkg::MODE_SKIP;
							clr    = 1'b1;
						end else begin
							line_chars_d = line_chars_q + LW'(1);
							if (!colon_seen_q) begin
								if (c == clfr_pkg::CH_COLON) begin
									colon_seen_d = 1'b1;
								end else begin
									case (key_phase_q)
										clfr_pkg::PH_LEAD: begin
											if (!ws) begin
												if (c == clfr_pkg::key_text('0)) begin
													key_phase_d = clfr_pkg::PH_BODY;
													key_pos_d   = KW'(1);
												end else begin
													key_phase_d = clfr_pkg::PH_BAD;
												end
											end
										end
										clfr_pkg::PH_BODY: begin
											if (ws) begin
												key_phase_d = (key_pos_q == KW'(clfr_pkg::KEY_LEN))
													? clfr_pkg::PH_TAIL : clfr_pkg::PH_BAD;
											end else if (key_pos_q < KW'(clfr_pkg::KEY_LEN)
												&& c == clfr_pkg::key_text(key_pos_q)) begin
												key_pos_d = key_pos_q + KW'(1);
											end else begin
												key_phase_d = clfr_pkg::PH_BAD;
											end
										end
										clfr_pkg::PH_TAIL: begin
											if (!ws) begin
												key_phase_d = clfr_pkg::PH_BAD;
											end
										end
										default: ;
									endcase
								end
							end else begin
								// value: leading digits only, rest of the line ignored
								if ((value_phase_q == clfr_pkg::PH_LEAD && !ws)
									|| value_phase_q == clfr_pkg::PH_BODY) begin
									if (!digit) begin
										value_phase_d = (value_phase_q == clfr_pkg::PH_LEAD)
											? clfr_pkg::PH_BAD : clfr_pkg::PH_TAIL;
									end else begin
										value_phase_d = clfr_pkg::PH_BODY;
										if (value_ovf_q || acc_ovf) begin
											value_ovf_d = 1'b1;
										end else begin
											value_acc_d = acc_next[LB-1:0];
										end
									end
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
		if (clr) begin
			line_chars_d  = '0;
			key_phase_d   = clfr_pkg::PH_LEAD;
			key_pos_d     = '0;
			colon_seen_d  = 1'b0;
			value_phase_d = clfr_pkg::PH_LEAD;
			value_acc_d   = '0;
			value_ovf_d   = 1'b0;
		end
	end

	// result
	always_comb begin
		res_valid        = 1'b0;
		res.kind         = clfr_pkg::KIND_DATA;
		res.payload_byte = 8'h00;
		res.last         = 1'b0;
		res.length       = '0;
		if (item.opcode == clfr_pkg::OP_DECISION) begin
			if (mode_q == clfr_pkg::MODE_WAIT) begin
				res_valid = advance;
				res.kind  = item.accept ? clfr_pkg::KIND_GO : clfr_pkg::KIND_NO_GO;
			end
		end else begin
			unique case (mode_q)
				clfr_pkg::MODE_WAIT: begin
					res_valid = advance;
					res.kind  = clfr_pkg::KIND_ABORTED;
				end
				clfr_pkg::MODE_DATA: begin
					res_valid        = advance;
					res.kind         = clfr_pkg::KIND_DATA;
					res.payload_byte = c;
					res.last         = (remain_q == LB'(1));
				end
				clfr_pkg::MODE_SKIP: ;
				clfr_pkg::MODE_HEADERS: begin
					if (lf) begin
						if (line_chars_q == '0) begin
							res_valid  = advance;
							res.kind   = clfr_pkg::KIND_FILE_REQ;
							res.length = clfr_pkg::LEN_OUT_W'(file_len_q);
						end else if (!colon_seen_q) begin
							res_valid = advance;
							res.kind  = clfr_pkg::KIND_NO_COLON;
						end else if (key_ok && !value_ok) begin
							res_valid = advance;
							res.kind  = clfr_pkg::KIND_BAD_LEN;
						end
					end else if (line_full) begin
						res_valid = advance;
						res.kind  = clfr_pkg::KIND_TOO_LONG;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= clfr_pkg::MODE_HEADERS;
			key_phase_q   <= clfr_pkg::PH_LEAD;
			value_phase_q <= clfr_pkg::PH_LEAD;
			line_chars_q  <= '0;
			key_pos_q     <= '0;
			colon_seen_q  <= 1'b0;
			value_acc_q   <= '0;
			value_ovf_q   <= 1'b0;
			file_len_q    <= '0;
			remain_q      <= '0;
		end else begin
			mode_q        <= mode_d;
			key_phase_q   <= key_phase_d;
			value_phase_q <= value_phase_d;
			line_chars_q  <= line_chars_d;
			key_pos_q     <= key_pos_d;
			colon_seen_q  <= colon_seen_d;
			value_acc_q   <= value_acc_d;
			value_ovf_q   <= value_ovf_d;
			file_len_q    <= file_len_d;
			remain_q      <= remain_d;
		end
	end

endmodule

/* sv/clfr_out_reg.sv */
// Result register: holds one result until the consumer takes it.
module clfr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  clfr_pkg::result_t res,
	input  logic              result_ready,
	output logic              result_valid,
	output clfr_pkg::result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= load || (result_valid && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

/* sv/content_length_frame_receiver_top.sv */
// Top level of the Content-Length deframer: input stage, core, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_ready    | opcode, data_byte, accept
//  result   | result_valid / result_ready| kind, payload_byte, last, length
//
// One request per cycle sustained while result_ready stays high. A taken request
// waits in the input register; any result it yields is loaded into the result
// register as the core consumes it, which it does whenever the result register is
// empty or being drained, so a stalled consumer backs up only these two registers.
// Reset (arst_n low) returns the parser to header mode with length zero.
module content_length_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        accept,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last,
	output logic [63:0] length
);

	clfr_pkg::item_t   item_in, item_s1;
	clfr_pkg::result_t res, res_q;
	logic              valid_s1, advance, res_valid;

	assign item_in.opcode    = opcode;
	assign item_in.data_byte = data_byte;
	assign item_in.accept    = accept;

	assign advance = valid_s1 && (!result_valid || result_ready);

	clfr_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_in    (item_in),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	clfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	clfr_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_valid),
		.res          (res),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.res_q        (res_q)
	);

	assign kind         = 3'(res_q.kind);
	assign payload_byte = res_q.payload_byte;
	assign last         = res_q.last;
	assign length       = res_q.length;

endmodule
